// ===== rtl/hsc_pkg.sv =====
// Package for the Hamming SEC codec: field widths, codes and position tables.
package hsc_pkg;

  localparam int DATA_BITS   = 56;
  localparam int CODE_BITS   = 62;
  localparam int SYN_BITS    = 6;
  localparam int FIELD_BYTES = 7;

  // Command codes
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_CORR    = 2'd1,
    STAT_UNCORR  = 2'd2
  } status_t;

  typedef logic [DATA_BITS-1:0][SYN_BITS-1:0] pos_arr_t;

  // Codeword position of each data bit: positions that are not powers of two
  function automatic pos_arr_t build_pos();
    pos_arr_t a;
    int j;
    a = '0;
    j = 0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (((p & (p - 1)) != 0) && (j < DATA_BITS)) begin
        a[j] = SYN_BITS'(p);
        j++;
      end
    end
    return a;
  endfunction

  localparam pos_arr_t DATA_POS = build_pos();

  // Positions p whose bit c is set, as a mask over codeword bits p-1
  function automatic logic [CODE_BITS-1:0] syn_mask(input int c);
    logic [CODE_BITS-1:0] msk;
    msk = '0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (((p >> c) & 1) != 0) msk[p-1] = 1'b1;
    end
    return msk;
  endfunction

  // Codeword length n for an effective byte count m
  function automatic logic [SYN_BITS-1:0] n_of(input logic [2:0] m);
    logic [SYN_BITS-1:0] n;
    case (m)
      3'd1:    n = 6'd12;
      3'd2:    n = 6'd21;
      3'd3:    n = 6'd29;
      3'd4:    n = 6'd38;
      3'd5:    n = 6'd46;
      3'd6:    n = 6'd54;
      3'd7:    n = 6'd62;
      default: n = 6'd12;
    endcase
    return n;
  endfunction

  // Byte shift that aligns m data bytes to the top of the data field
  function automatic logic [SYN_BITS-1:0] align_shift(input logic [2:0] m);
    logic [2:0] gap;
    gap = 3'(FIELD_BYTES) - m;
    return {gap, 3'b000};
  endfunction

endpackage

// ===== rtl/hamming_sec_codec.sv =====
// Top level of the Hamming single-error-correcting codec (three-stage pipeline).
//
// Hamming SEC codec for rows of 8*m data bits, m set by cfg_wdata (0 reads as 1,
// values above MAX_DATA_BYTES read as MAX_DATA_BYTES). cmd 0 encodes data_in into
// code_out; cmd 1 decodes code_in, corrects a single-bit error and reports the
// syndrome and status (0 clean, 1 corrected, 2 syndrome beyond the word). One item
// is taken every cycle unless all stages are full and out_tready is low; each
// result passes through the three register stages: alignment and masking, the
// syndrome XOR trees, and correction with data extraction. A stall on the
// output holds the full stages while empty ones still fill, and backs up into
// in_tready only when all stages are full. Write the byte count only while no
// item is in flight.
module hamming_sec_codec #(
  parameter int MAX_DATA_BYTES = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_wdata,     // data_bytes
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,      // data_in[55:0], code_in[117:56], zero pad
  input  logic [0:0]   in_tuser,      // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata      // code_out[61:0], data_out[117:62],
                                      // syndrome[123:118], status[125:124], zero pad
);

  localparam int DB = hsc_pkg::DATA_BITS;
  localparam int CB = hsc_pkg::CODE_BITS;
  localparam int SB = hsc_pkg::SYN_BITS;
  localparam logic [2:0] MAX_M = 3'(MAX_DATA_BYTES);

  // Configuration register
  logic [2:0] data_bytes_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bytes_r <= 3'd1;
    end else if (cfg_wen) begin
      data_bytes_r <= cfg_wdata;
    end
  end

  logic [2:0] eff_m;
  always_comb begin
    if (data_bytes_r == 3'd0) begin
      eff_m = 3'd1;
    end else if (data_bytes_r > MAX_M) begin
      eff_m = MAX_M;
    end else begin
      eff_m = data_bytes_r;
    end
  end

  // Pipeline enables: a stage loads when it is empty or its content moves on
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  assign en3 = !v3_r || out_tready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Stage 1: place data bits for encode, mask received word for decode
  logic [DB-1:0] data_in;
  logic [CB-1:0] code_in;
  logic [DB-1:0] data_al;
  logic [CB-1:0] word_enc;
  logic [CB-1:0] n_mask;
  logic [CB-1:0] word1_nxt;

  assign data_in = in_tdata[DB-1:0];
  assign code_in = in_tdata[DB+CB-1:DB];
  assign data_al = data_in << hsc_pkg::align_shift(eff_m);
  assign n_mask  = {CB{1'b1}} >> (SB'(CB) - hsc_pkg::n_of(eff_m));

  always_comb begin
    word_enc = '0;
    for (int j = 0; j < DB; j++) begin
      word_enc[hsc_pkg::DATA_POS[j] - 1] = data_al[DB-1-j];
    end
  end

  assign word1_nxt = (in_tuser[0] == hsc_pkg::CMD_DECODE) ? (code_in & n_mask) : word_enc;

  logic          cmd1_r;
  logic [2:0]    m1_r;
  logic [CB-1:0] word1_r;
  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1_r  <= in_tuser[0];
      m1_r    <= eff_m;
      word1_r <= word1_nxt;
    end
  end

  // Stage 2: syndrome, which on encode is the set of check bits
  logic [SB-1:0] syn2_nxt;
  always_comb begin
    for (int c = 0; c < SB; c++) begin
      syn2_nxt[c] = ^(word1_r & hsc_pkg::syn_mask(c));
    end
  end

  logic          cmd2_r;
  logic [2:0]    m2_r;
  logic [CB-1:0] word2_r;
  logic [SB-1:0] syn2_r;
  always_ff @(posedge clk) begin
    if (en2) begin
      cmd2_r  <= cmd1_r;
      m2_r    <= m1_r;
      word2_r <= word1_r;
      syn2_r  <= syn2_nxt;
    end
  end

  // Stage 3: insert check bits, or correct and extract data
  logic [CB-1:0]   code_chk;
  logic [CB-1:0]   word_fix;
  logic [DB-1:0]   ext_al;
  logic            in_word;
  logic [CB-1:0]   code3_nxt;
  logic [DB-1:0]   data3_nxt;
  logic [SB-1:0]   syn3_nxt;
  hsc_pkg::status_t stat3_nxt;

  always_comb begin
    code_chk = word2_r;
    for (int c = 0; c < SB; c++) begin
      code_chk[(1 << c) - 1] = word2_r[(1 << c) - 1] | syn2_r[c];
    end
  end

  assign in_word  = (syn2_r != '0) && (syn2_r <= hsc_pkg::n_of(m2_r));
  assign word_fix = in_word ? (word2_r ^ (CB'(1) << (syn2_r - SB'(1)))) : word2_r;

  always_comb begin
    ext_al = '0;
    for (int j = 0; j < DB; j++) begin
      ext_al[DB-1-j] = word_fix[hsc_pkg::DATA_POS[j] - 1];
    end
  end

  always_comb begin
    if (cmd2_r == hsc_pkg::CMD_DECODE) begin
      code3_nxt = '0;
      data3_nxt = ext_al >> hsc_pkg::align_shift(m2_r);
      syn3_nxt  = syn2_r;
      if (syn2_r == '0) begin
        stat3_nxt = hsc_pkg::STAT_OK;
      end else if (in_word) begin
        stat3_nxt = hsc_pkg::STAT_CORR;
      end else begin
        stat3_nxt = hsc_pkg::STAT_UNCORR;
      end
    end else begin
      code3_nxt = code_chk;
      data3_nxt = '0;
      syn3_nxt  = '0;
      stat3_nxt = hsc_pkg::STAT_OK;
    end
  end

  logic [CB-1:0]    code3_r;
  logic [DB-1:0]    data3_r;
  logic [SB-1:0]    syn3_r;
  hsc_pkg::status_t stat3_r;
  always_ff @(posedge clk) begin
    if (en3) begin
      code3_r <= code3_nxt;
      data3_r <= data3_nxt;
      syn3_r  <= syn3_nxt;
      stat3_r <= stat3_nxt;
    end
  end

  // Drive the result channel
  assign out_tvalid = v3_r;
  assign out_tdata  = {2'b00, stat3_r, syn3_r, data3_r, code3_r};

endmodule
